[rtl/core/tsaa_pkg.sv]
// Shared types and constants for the temperature sensor average and alarm block.
// Holds field widths, conversion constants, the register map and the result struct.
// No dependencies.
`timescale 1ns / 1ps

package tsaa_pkg;

	// Field widths
	localparam int ADC_W  = 12;
	localparam int TEMP_W = 17;
	localparam int THR_W  = 13;

	// Default run lengths
	localparam int SAMPLES_PER_READING_DEF = 3;
	localparam int READINGS_PER_BLOCK_DEF  = 14;

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_ALARM_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0]     THR_RESET           = 13'd3700;

	// Code to millivolts in Q16: m = avg * 3300 * 65536 / 4095 = avg * 14417920 / 273.
	localparam int SCALE_W = 24;
	localparam logic [SCALE_W-1:0] MV_SCALE = 24'd14417920;
	localparam int MV_DIV_W = 9;
	localparam logic [MV_DIV_W-1:0] MV_DIV = 9'd273;
	localparam int MV_W = 28;

	// Square of the millivolt value, Q16
	localparam int SQ_W = 40;
	localparam int SQ_SHIFT = 16;

	// Linear and quadratic coefficients in units of 1e-6 hundredth degC
	localparam int LIN_W = 25;
	localparam logic [LIN_W-1:0] LIN_COEF = 25'd17775010;
	localparam int QUAD_W = 23;
	localparam logic [QUAD_W-1:0] QUAD_COEF = 23'd7857923;
	localparam int QUAD_DIV_W = 14;
	localparam logic [QUAD_DIV_W-1:0] QUAD_DIV = 14'd10000;

	// Accumulator and final scaling: 1e6 * 65536 = 2^22 * 15625
	localparam int ACC_W = 54;
	localparam logic [ACC_W-1:0] ACC_BASE = 54'd20463980000 << 16;
	localparam int UNIT_SHIFT = 22;
	localparam int UNIT_DIV_W = 14;
	localparam logic [UNIT_DIV_W-1:0] UNIT_DIV = 14'd15625;

	// Conversion result handed from the converter to the top level
	typedef struct packed {
		logic                     done;
		logic signed [TEMP_W-1:0] temp;
	} conv_result_t;

endpackage

[rtl/core/tsaa_in_if.sv]
// Input channel of the temperature block: one ADC code and the clock alarm flag.
// Valid/ready handshake. Depends on tsaa_pkg.
`timescale 1ns / 1ps

interface tsaa_in_if;
	import tsaa_pkg::*;

	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_code;
	logic             clock_alarm_busy;

	modport source(output valid, adc_code, clock_alarm_busy, input ready);
	modport sink(input valid, adc_code, clock_alarm_busy, output ready);

endinterface

[rtl/core/tsaa_out_if.sv]
// Result channel of the temperature block: reading, block average and alarm level.
// Valid/ready handshake. Depends on tsaa_pkg.
`timescale 1ns / 1ps

interface tsaa_out_if;
	import tsaa_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature;
	logic                     block_average_valid;
	logic signed [TEMP_W-1:0] block_average;
	logic                     over_threshold_alarm;

	modport source(output valid, temperature, block_average_valid, block_average,
		over_threshold_alarm, input ready);
	modport sink(input valid, temperature, block_average_valid, block_average,
		over_threshold_alarm, output ready);

endinterface

[rtl/core/temp_sensor_average_alarm_top.sv]
// Top level of the temperature sensor block: sample collection, block average, alarm
// and the configuration port. Depends on tsaa_pkg, tsaa_in_if, tsaa_out_if,
// tsaa_convert and tsaa_serial_div.
`timescale 1ns / 1ps

// Every SAMPLES_PER_READING accepted ADC codes form one reading; the block then emits one
// result with the temperature in 0.01 degC, the block average when the reading closes a
// run of READINGS_PER_BLOCK readings (zero otherwise) and the alarm level. A code that
// does not close a reading is absorbed and produces no result. A code that
// closes a reading starts a chain of bit-serial dividers and multipliers, one bit per
// cycle each, and no further code is accepted until the result is in the output
// register, and when a run completes the serial divide of the block sum comes on top.
// The 63-bit divide by 10000 of the quadratic term is the longest single step. The alarm
// threshold register sits at byte address 0 and resets to 37.00 degC; the alarm level
// holds while clock_alarm_busy is set on the code that closes a reading.
module temp_sensor_average_alarm_top #(
	parameter int SAMPLES_PER_READING = tsaa_pkg::SAMPLES_PER_READING_DEF,
	parameter int READINGS_PER_BLOCK  = tsaa_pkg::READINGS_PER_BLOCK_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tsaa_in_if.sink                        sample_in,
	tsaa_out_if.source                     result_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tsaa_pkg::PADDR_W-1:0]   paddr,
	input  logic [tsaa_pkg::PDATA_W-1:0]   pwdata,
	output logic [tsaa_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	import tsaa_pkg::*;

	localparam int SUM_W = ADC_W + $clog2(SAMPLES_PER_READING);
	localparam int SC_W  = $clog2(SAMPLES_PER_READING + 1);
	localparam int RC_W  = $clog2(READINGS_PER_BLOCK);
	localparam int RS_W  = TEMP_W + $clog2(READINGS_PER_BLOCK);
	localparam int RD_W  = $clog2(READINGS_PER_BLOCK + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_BLK,
		ST_HOLD
	} state_t;

	state_t state_q;

	logic [THR_W-1:0]          thr_q;
	logic [SC_W-1:0]           sample_count_q;
	logic [SUM_W-1:0]          sample_sum_q;
	logic                      busy_hold_q;
	logic [RC_W-1:0]           reading_count_q;
	logic [RS_W-1:0]           reading_sum_q;
	logic                      alarm_q;
	logic [TEMP_W-1:0]         temp_q;
	logic                      blk_valid_q;
	logic [TEMP_W-1:0]         blk_avg_q;
	logic                      blk_neg_q;
	logic                      out_valid_q;
	logic [TEMP_W-1:0]         out_temp_q;
	logic                      out_blk_valid_q;
	logic [TEMP_W-1:0]         out_blk_avg_q;
	logic                      out_alarm_q;

	conv_result_t      conv_res;
	logic              in_xfer;
	logic              last_sample;
	logic              conv_start;
	logic [SUM_W-1:0]  sum_next;
	logic [RS_W-1:0]   rs_next;
	logic [RS_W-1:0]   rs_mag;
	logic              last_reading;
	logic              blk_start;
	logic              blk_done;
	logic [RS_W-1:0]   blk_quot;
	logic [TEMP_W-1:0] blk_q17;
	logic              temp_ge;
	logic              out_load;
	logic              thr_write;

	assign sample_in.ready = (state_q == ST_IDLE);
	assign in_xfer         = sample_in.valid && sample_in.ready;
	assign sum_next        = sample_sum_q + SUM_W'(sample_in.adc_code);
	assign last_sample     = (sample_count_q == SC_W'(SAMPLES_PER_READING - 1));
	assign conv_start      = in_xfer && last_sample;

	assign rs_next = reading_sum_q
		+ {{(RS_W - TEMP_W){conv_res.temp[TEMP_W-1]}}, conv_res.temp};
	assign rs_mag       = rs_next[RS_W-1] ? (~rs_next + 1'b1) : rs_next;
	assign last_reading = (reading_count_q == RC_W'(READINGS_PER_BLOCK - 1));
	assign blk_start    = (state_q == ST_CONV) && conv_res.done && last_reading;
	assign blk_q17      = blk_quot[TEMP_W-1:0];

	// Signed reading against the unsigned threshold, both widened to TEMP_W + 1 bits.
	assign temp_ge = $signed({conv_res.temp[TEMP_W-1], conv_res.temp})
		>= $signed({{(TEMP_W + 1 - THR_W){1'b0}}, thr_q});

	assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || result_out.ready);
	assign thr_write = psel && penable && pwrite
		&& (paddr[PADDR_W-1:2] == REG_ALARM_THRESHOLD);

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_ALARM_THRESHOLD)
		? {{(PDATA_W - THR_W){1'b0}}, thr_q} : '0;

	tsaa_convert #(.SAMPLES_PER_READING(SAMPLES_PER_READING)) u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (conv_start),
		.sample_sum(sum_next),
		.result    (conv_res)
	);

	// Block mean: magnitude of the run sum over the run length, sign restored afterwards.
	tsaa_serial_div #(.NUM_W(RS_W), .DEN_W(RD_W)) u_blkdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (blk_start),
		.num   (rs_mag),
		.den   (RD_W'(READINGS_PER_BLOCK)),
		.done  (blk_done),
		.quot  (blk_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			thr_q           <= THR_RESET;
			sample_count_q  <= '0;
			sample_sum_q    <= '0;
			busy_hold_q     <= 1'b0;
			reading_count_q <= '0;
			reading_sum_q   <= '0;
			alarm_q         <= 1'b0;
			temp_q          <= '0;
			blk_valid_q     <= 1'b0;
			blk_avg_q       <= '0;
			blk_neg_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			out_temp_q      <= '0;
			out_blk_valid_q <= 1'b0;
			out_blk_avg_q   <= '0;
			out_alarm_q     <= 1'b0;
		end else begin
			if (thr_write) thr_q <= pwdata[THR_W-1:0];

			if (result_out.valid && result_out.ready && !out_load) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (last_sample) begin
							sample_count_q <= '0;
							sample_sum_q   <= '0;
							busy_hold_q    <= sample_in.clock_alarm_busy;
							state_q        <= ST_CONV;
						end else begin
							sample_count_q <= sample_count_q + 1'b1;
							sample_sum_q   <= sum_next;
						end
					end
				end
				ST_CONV: begin
					if (conv_res.done) begin
						temp_q <= conv_res.temp;
						if (!busy_hold_q) alarm_q <= temp_ge;
						if (last_reading) begin
							reading_count_q <= '0;
							reading_sum_q   <= '0;
							blk_neg_q       <= rs_next[RS_W-1];
							state_q         <= ST_BLK;
						end else begin
							reading_count_q <= reading_count_q + 1'b1;
							reading_sum_q   <= rs_next;
							blk_valid_q     <= 1'b0;
							blk_avg_q       <= '0;
							state_q         <= ST_HOLD;
						end
					end
				end
				ST_BLK: begin
					if (blk_done) begin
						blk_avg_q   <= blk_neg_q ? (~blk_q17 + 1'b1) : blk_q17;
						blk_valid_q <= 1'b1;
						state_q     <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// Wait here until the previous result has been transferred.
					if (out_load) begin
						out_valid_q     <= 1'b1;
						out_temp_q      <= temp_q;
						out_blk_valid_q <= blk_valid_q;
						out_blk_avg_q   <= blk_avg_q;
						out_alarm_q     <= alarm_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_out.valid                = out_valid_q;
	assign result_out.temperature          = out_temp_q;
	assign result_out.block_average_valid  = out_blk_valid_q;
	assign result_out.block_average        = out_blk_avg_q;
	assign result_out.over_threshold_alarm = out_alarm_q;

endmodule

[rtl/core/tsaa_serial_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Generic over numerator and denominator widths; no package dependency.
`timescale 1ns / 1ps

module tsaa_serial_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] shift_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	// The numerator shifts out from the top while quotient bits shift in below.
	assign trial = {rem_q, shift_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= num;
			rem_q   <= '0;
			den_q   <= den;
		end else if (run_q) begin
			shift_q <= {shift_q[NUM_W-2:0], fits};
			rem_q   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = shift_q;

endmodule

[rtl/core/tsaa_serial_mul.sv]
// Bit-serial shift-add multiplier, one bit of operand b per cycle, unsigned.
// Generic over operand widths; no package dependency.
`timescale 1ns / 1ps

module tsaa_serial_mul #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic                 done,
	output logic [A_W+B_W-1:0]   prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [A_W-1:0]   a_q;
	logic [A_W-1:0]   hi_q;
	logic [B_W-1:0]   lo_q;

	logic [A_W:0] partial;

	// The low half starts as operand b and fills with product bits from the top.
	assign partial = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= partial[A_W:1];
			lo_q <= {partial[0], lo_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

[rtl/core/tsaa_convert.sv]
// Sequencer that turns a sum of ADC codes into one temperature reading in 0.01 degC.
// Chains bit-serial dividers and multipliers; depends on tsaa_pkg, tsaa_serial_div
// and tsaa_serial_mul.
`timescale 1ns / 1ps

module tsaa_convert #(
	parameter int SAMPLES_PER_READING = tsaa_pkg::SAMPLES_PER_READING_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsaa_pkg::ADC_W+$clog2(SAMPLES_PER_READING)-1:0] sample_sum,
	output tsaa_pkg::conv_result_t      result
);

	import tsaa_pkg::*;

	localparam int SUM_W      = ADC_W + $clog2(SAMPLES_PER_READING);
	localparam int CNT_DEN_W  = $clog2(SAMPLES_PER_READING + 1);
	localparam int SCALED_W   = SCALE_W + ADC_W;
	localparam int LINP_W     = LIN_W + MV_W;
	localparam int QUADP_W    = SQ_W + QUAD_W;
	localparam int UNIT_NUM_W = ACC_W - UNIT_SHIFT;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVN,
		S_SCALE,
		S_MVDIV,
		S_SQLIN,
		S_QUAD,
		S_QDIV,
		S_ABS,
		S_UNIT
	} state_t;

	state_t state_q;
	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [ACC_W-1:0]         acc_q;
	logic                     neg_q;

	logic                  divn_done;
	logic [SUM_W-1:0]      divn_quot;
	logic                  scale_start;
	logic                  scale_done;
	logic [SCALED_W-1:0]   scale_prod;
	logic                  mvdiv_start;
	logic                  mvdiv_done;
	logic [SCALED_W-1:0]   mvdiv_quot;
	logic                  sqlin_start;
	logic                  sq_done;
	logic [2*MV_W-1:0]     sq_prod;
	logic                  lin_done;
	logic [LINP_W-1:0]     lin_prod;
	logic                  quad_start;
	logic                  quad_done;
	logic [QUADP_W-1:0]    quad_prod;
	logic                  qdiv_start;
	logic                  qdiv_done;
	logic [QUADP_W-1:0]    qdiv_quot;
	logic                  unit_start;
	logic                  unit_done;
	logic [UNIT_NUM_W-1:0] unit_quot;

	logic [MV_W-1:0]   mv;
	logic [SQ_W-1:0]   mv_sq;
	logic [ACC_W-1:0]  acc_mag;
	logic [TEMP_W-1:0] unit_q17;

	assign mv       = mvdiv_quot[MV_W-1:0];
	assign mv_sq    = sq_prod[2*MV_W-1:SQ_SHIFT];
	assign acc_mag  = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign unit_q17 = unit_quot[TEMP_W-1:0];

	always_comb begin
		scale_start = (state_q == S_DIVN) && divn_done;
		mvdiv_start = (state_q == S_SCALE) && scale_done;
		sqlin_start = (state_q == S_MVDIV) && mvdiv_done;
		quad_start  = (state_q == S_SQLIN) && sq_done && lin_done;
		qdiv_start  = (state_q == S_QUAD) && quad_done;
		unit_start  = (state_q == S_ABS);
	end

	// Mean of the collected codes
	tsaa_serial_div #(.NUM_W(SUM_W), .DEN_W(CNT_DEN_W)) u_divn (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.num   (sample_sum),
		.den   (CNT_DEN_W'(SAMPLES_PER_READING)),
		.done  (divn_done),
		.quot  (divn_quot)
	);

	tsaa_serial_mul #(.A_W(SCALE_W), .B_W(ADC_W)) u_scale (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scale_start),
		.a     (MV_SCALE),
		.b     (divn_quot[ADC_W-1:0]),
		.done  (scale_done),
		.prod  (scale_prod)
	);

	tsaa_serial_div #(.NUM_W(SCALED_W), .DEN_W(MV_DIV_W)) u_mvdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mvdiv_start),
		.num   (scale_prod),
		.den   (MV_DIV),
		.done  (mvdiv_done),
		.quot  (mvdiv_quot)
	);

	// Square and linear term run side by side over the same number of cycles.
	tsaa_serial_mul #(.A_W(MV_W), .B_W(MV_W)) u_sq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqlin_start),
		.a     (mv),
		.b     (mv),
		.done  (sq_done),
		.prod  (sq_prod)
	);

	tsaa_serial_mul #(.A_W(LIN_W), .B_W(MV_W)) u_lin (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqlin_start),
		.a     (LIN_COEF),
		.b     (mv),
		.done  (lin_done),
		.prod  (lin_prod)
	);

	tsaa_serial_mul #(.A_W(SQ_W), .B_W(QUAD_W)) u_quad (
		.clk   (clk),
		.arst_n(arst_n),
		.start (quad_start),
		.a     (mv_sq),
		.b     (QUAD_COEF),
		.done  (quad_done),
		.prod  (quad_prod)
	);

	tsaa_serial_div #(.NUM_W(QUADP_W), .DEN_W(QUAD_DIV_W)) u_qdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (qdiv_start),
		.num   (quad_prod),
		.den   (QUAD_DIV),
		.done  (qdiv_done),
		.quot  (qdiv_quot)
	);

	// Division by 2^22 is the part-select; the rest is a serial divide by 15625.
	tsaa_serial_div #(.NUM_W(UNIT_NUM_W), .DEN_W(UNIT_DIV_W)) u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.start (unit_start),
		.num   (acc_mag[ACC_W-1:UNIT_SHIFT]),
		.den   (UNIT_DIV),
		.done  (unit_done),
		.quot  (unit_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			temp_q  <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			done_q <= (state_q == S_UNIT) && unit_done;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DIVN;
				end
				S_DIVN: begin
					if (divn_done) state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (scale_done) state_q <= S_MVDIV;
				end
				S_MVDIV: begin
					if (mvdiv_done) state_q <= S_SQLIN;
				end
				S_SQLIN: begin
					if (sq_done && lin_done) begin
						acc_q   <= ACC_BASE - ACC_W'(lin_prod);
						state_q <= S_QUAD;
					end
				end
				S_QUAD: begin
					if (quad_done) state_q <= S_QDIV;
				end
				S_QDIV: begin
					if (qdiv_done) begin
						acc_q   <= acc_q - qdiv_quot[ACC_W-1:0];
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					neg_q   <= acc_q[ACC_W-1];
					state_q <= S_UNIT;
				end
				S_UNIT: begin
					if (unit_done) begin
						// Truncation toward zero: divide the magnitude, then restore the sign.
						temp_q  <= neg_q ? (~unit_q17 + 1'b1) : unit_q17;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.done = done_q;
	assign result.temp = temp_q;

endmodule

[verif/temp_sensor_average_alarm_top_tb.sv]
// Testbench for temp_sensor_average_alarm_top: directed and random ADC code streams with
// random idling on both channels, checked against an in-bench fixed-point temperature model.
// Depends on tsaa_pkg, tsaa_in_if, tsaa_out_if and the block's RTL.
`timescale 1ns / 1ps

module temp_sensor_average_alarm_top_tb;
	import tsaa_pkg::*;

	localparam int CODES_PER_READING   = SAMPLES_PER_READING_DEF;
	localparam int READINGS_PER_RUN    = READINGS_PER_BLOCK_DEF;
	localparam int SETTLE_CYCLES       = 300;
	localparam int CYCLE_LIMIT         = 800000;
	localparam int MAX_REPORTS         = 10;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;
	localparam longint CENTI_SCALE     = 64'sd1000000 * 64'sd65536;
	localparam longint BASE_Q16        = 64'sd20463980000 * 64'sd65536;

	typedef struct packed {
		logic [ADC_W-1:0] code;
		logic             busy;
	} code_item_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic                     average_valid;
		logic signed [TEMP_W-1:0] block_average;
		logic                     alarm;
	} reading_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	tsaa_in_if  smp_if();
	tsaa_out_if res_if();

	temp_sensor_average_alarm_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (smp_if),
		.result_out(res_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Model of the block's state.
	logic [THR_W-1:0] threshold_model;
	int unsigned      code_tally;
	int unsigned      code_sum;
	int unsigned      reading_tally;
	longint           reading_total;
	logic             alarm_model;

	code_item_t pending_codes[$];
	reading_t   expected_readings[$];

	logic code_xfer;
	logic result_xfer;
	bit   code_steady;
	bit   result_steady;
	int unsigned code_gap;
	int unsigned result_stall;

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned codes_sent;
	int unsigned readings_checked;
	int unsigned averages_checked;
	int unsigned alarms_seen;
	int unsigned threshold_writes;

	always #1 clk = ~clk;

	function automatic void note_failure(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("MISMATCH: %s", msg);
	endfunction

	function automatic int unsigned pick_wait(bit steady);
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	// Temperature in 0.01 degC from a mean ADC code, every step truncating.
	function automatic longint centideg_from_code(logic [ADC_W-1:0] mean_code);
		longint unsigned mv_q16;
		longint unsigned mv_sq;
		longint          lin_term;
		longint          quad_term;
		longint          acc;
		mv_q16    = (64'(mean_code) * 64'd3300 * 64'd65536) / 64'd4095;
		mv_sq     = (mv_q16 * mv_q16) >> 16;
		lin_term  = longint'(mv_q16 * 64'd17775010);
		quad_term = longint'((mv_sq * 64'd7857923) / 64'd10000);
		acc       = BASE_Q16 - lin_term - quad_term;
		return acc / CENTI_SCALE;
	endfunction

	task automatic absorb_code(logic [ADC_W-1:0] code, logic busy);
		longint   temp_now;
		longint   avg_now;
		reading_t result;
		code_sum += code;
		code_tally++;
		if (code_tally == CODES_PER_READING) begin
			temp_now   = centideg_from_code(ADC_W'(code_sum / CODES_PER_READING));
			code_sum   = 0;
			code_tally = 0;
			reading_total += temp_now;
			reading_tally++;
			avg_now = 0;
			result.average_valid = 1'b0;
			if (reading_tally == READINGS_PER_RUN) begin
				avg_now = reading_total / longint'(READINGS_PER_RUN);
				result.average_valid = 1'b1;
				reading_total = 0;
				reading_tally = 0;
			end
			if (!busy)
				alarm_model = (temp_now >= longint'(threshold_model));
			result.temperature   = TEMP_W'(temp_now);
			result.block_average = TEMP_W'(avg_now);
			result.alarm         = alarm_model;
			expected_readings.push_back(result);
		end
	endtask

	// Input side: prediction on every transfer, driving on the falling edge.
	always @(posedge clk) begin
		code_xfer <= smp_if.valid && smp_if.ready;
		if (arst_n && smp_if.valid && smp_if.ready) begin
			codes_sent++;
			absorb_code(smp_if.adc_code, smp_if.clock_alarm_busy);
		end
	end

	always @(negedge clk) begin : drive_codes
		code_item_t nxt;
		if (arst_n && (!smp_if.valid || code_xfer)) begin
			if (code_gap > 0) begin
				code_gap--;
				smp_if.valid <= 1'b0;
			end else if (pending_codes.size() > 0) begin
				nxt = pending_codes.pop_front();
				smp_if.valid            <= 1'b1;
				smp_if.adc_code         <= nxt.code;
				smp_if.clock_alarm_busy <= nxt.busy;
				if ($urandom_range(0, 31) == 0)
					code_steady = !code_steady;
				code_gap = pick_wait(code_steady);
			end else begin
				smp_if.valid <= 1'b0;
			end
		end
	end

	// Result side: stalls drawn per result, comparison on every transfer.
	always @(negedge clk) begin
		if (arst_n && (!res_if.ready || result_xfer)) begin
			if (result_stall > 0) begin
				result_stall--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
				if ($urandom_range(0, 31) == 0)
					result_steady = !result_steady;
				result_stall = pick_wait(result_steady);
			end
		end
	end

	always @(posedge clk) begin : check_results
		reading_t want;
		result_xfer <= res_if.valid && res_if.ready;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_readings.size() == 0) begin
				note_failure($sformatf("result with no reading pending: temp %0d avg %0d/%0b alarm %0b",
					res_if.temperature, res_if.block_average, res_if.block_average_valid,
					res_if.over_threshold_alarm));
			end else begin
				want = expected_readings.pop_front();
				readings_checked++;
				if (want.average_valid)
					averages_checked++;
				if (want.alarm)
					alarms_seen++;
				if (res_if.temperature !== want.temperature
						|| res_if.block_average_valid !== want.average_valid
						|| res_if.block_average !== want.block_average
						|| res_if.over_threshold_alarm !== want.alarm)
					note_failure($sformatf({"reading %0d: expected temp %0d avg %0d/%0b alarm %0b, ",
						"got temp %0d avg %0d/%0b alarm %0b"}, readings_checked,
						want.temperature, want.block_average, want.average_valid, want.alarm,
						res_if.temperature, res_if.block_average, res_if.block_average_valid,
						res_if.over_threshold_alarm));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		if (wr && idx == REG_ALARM_THRESHOLD)
			threshold_model = data[THR_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic confirm_threshold();
		logic [PDATA_W-1:0] rd;
		logic [PDATA_W-1:0] want;
		want = '0;
		want[THR_W-1:0] = threshold_model;
		apb_access(1'b0, REG_ALARM_THRESHOLD, '0, rd);
		if (rd !== want)
			note_failure($sformatf("threshold readback: expected %0d, got %0d", want, rd));
	endtask

	task automatic set_threshold(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] unused;
		apb_access(1'b1, idx, data, unused);
		threshold_writes++;
		confirm_threshold();
	endtask

	task automatic queue_code(logic [ADC_W-1:0] code, logic busy);
		code_item_t item;
		item.code = code;
		item.busy = busy;
		pending_codes.push_back(item);
	endtask

	task automatic queue_random_codes(int unsigned count, int unsigned code_hi);
		int unsigned      pick;
		logic [ADC_W-1:0] code;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				code = '0;
			else if (pick == 1)
				code = '1;
			else
				code = ADC_W'($urandom_range(0, code_hi));
			queue_code(code, $urandom_range(0, 3) == 0);
		end
	endtask

	// Waits until every code is taken and every reading has come back, then lets the
	// conversion chain run out before the next register write.
	task automatic settle();
		while (pending_codes.size() != 0 || smp_if.valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp_if.valid = 1'b0;
		smp_if.adc_code = '0;
		smp_if.clock_alarm_busy = 1'b0;
		res_if.ready = 1'b0;
		code_xfer = 1'b0;
		result_xfer = 1'b0;
		threshold_model = THR_RESET;
		code_tally = 0;
		code_sum = 0;
		reading_tally = 0;
		reading_total = 0;
		alarm_model = 1'b0;
		code_gap = 0;
		result_stall = 0;
		error_count = 0;
		cycle_count = 0;
		codes_sent = 0;
		readings_checked = 0;
		averages_checked = 0;
		alarms_seen = 0;
		threshold_writes = 0;

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4)
			@(posedge clk);
		confirm_threshold();

		// Default threshold: hottest and coldest readings, a held alarm, a truncated mean.
		repeat (3)
			queue_code('0, 1'b0);
		queue_code('1, 1'b1);
		queue_code('1, 1'b1);
		queue_code('1, 1'b0);
		queue_code('0, 1'b0);
		queue_code('0, 1'b0);
		queue_code('0, 1'b1);
		queue_code('1, 1'b0);
		queue_code('1, 1'b0);
		queue_code(12'd4094, 1'b0);
		settle();

		// Threshold equal to a reading: the alarm fires on equality and clears one code above.
		set_threshold(REG_ALARM_THRESHOLD, PDATA_W'(centideg_from_code(12'd1000)));
		queue_code(12'd1000, 1'b0);
		queue_code(12'd1000, 1'b0);
		queue_code(12'd1002, 1'b0);
		repeat (3)
			queue_code(12'd1001, 1'b0);
		settle();

		// All-ones write keeps 13 bits, a threshold above the documented range.
		set_threshold(REG_ALARM_THRESHOLD, '1);
		repeat (3)
			queue_code('0, 1'b0);
		settle();

		// A write beyond the register map must leave the threshold alone.
		set_threshold(REG_UNMAPPED, '0);
		set_threshold(REG_ALARM_THRESHOLD, '0);
		queue_code(12'd2048, 1'b0);
		queue_code(12'd2047, 1'b0);
		queue_code(12'd2049, 1'b0);
		settle();

		// Random phases alternate full-scale codes with low codes for warm readings.
		set_threshold(REG_ALARM_THRESHOLD, PDATA_W'(5990));
		queue_random_codes(245, 4095);
		settle();
		set_threshold(REG_ALARM_THRESHOLD, PDATA_W'($urandom_range(0, 5990)));
		queue_random_codes(245, 1500);
		settle();
		set_threshold(REG_ALARM_THRESHOLD, PDATA_W'($urandom_range(0, 5990)));
		queue_random_codes(245, 4095);
		settle();
		set_threshold(REG_ALARM_THRESHOLD, PDATA_W'($urandom_range(0, 5990)));
		queue_random_codes(245, 1500);
		settle();

		$display("run: %0d codes in, %0d readings checked, %0d block averages, %0d with alarm on",
			codes_sent, readings_checked, averages_checked, alarms_seen);
		$display("run: %0d threshold writes, %0d cycles, %0d mismatches",
			threshold_writes, cycle_count, error_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
